### rtl/envc_pkg.sv
package envc_pkg;

  typedef logic signed [63:0] q_t;

  localparam q_t Q_MAX = {1'b0, {63{1'b1}}};
  localparam q_t Q_MIN = {1'b1, {63{1'b0}}};

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CAL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_C   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUMID_CAL = 3'd4;

  function automatic q_t sadd(input q_t a, input q_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
    return q_t'(s[63:0]);
  endfunction

  function automatic q_t ssub(input q_t a, input q_t b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
    return q_t'(s[63:0]);
  endfunction

  function automatic logic [63:0] qmag(input q_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Applies the sign to a floored magnitude quotient and saturates to the word.
  function automatic q_t sat_mag(input logic neg, input logic hi_nz, input logic [63:0] lo,
                                 input logic rem);
    logic [64:0] inc;
    q_t          res;
    inc = {1'b0, lo} + 65'(rem);
    if (!neg) begin
      res = (hi_nz || lo[63]) ? Q_MAX : q_t'(lo);
    end else if (hi_nz || inc[64] || inc[63]) begin
      res = Q_MIN;
    end else begin
      res = -q_t'(inc[63:0]);
    end
    return res;
  endfunction

endpackage

### rtl/envc_qmul.sv
module envc_qmul import envc_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int LANES     = 1,
  parameter int SW        = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  q_t            a [LANES],
  input  q_t            b [LANES],
  input  logic [SW-1:0] side_in,
  output logic          out_vld,
  output q_t            p [LANES],
  output logic [SW-1:0] side_out
);

  localparam int DEPTH = 6;

  logic [DEPTH-1:0] vld_r;
  logic [SW-1:0]    side_r [DEPTH];
  q_t               a_r [LANES];
  q_t               b_r [LANES];
  logic             neg1_r [LANES];
  logic             neg2_r [LANES];
  logic             neg3_r [LANES];
  logic             neg4_r [LANES];
  logic [63:0]      ma_r [LANES];
  logic [63:0]      mb_r [LANES];
  logic [63:0]      ll_r [LANES];
  logic [63:0]      lh_r [LANES];
  logic [63:0]      hl_r [LANES];
  logic [63:0]      hh_r [LANES];
  logic [127:0]     prod_r [LANES];
  logic [127:0]     sh [LANES];
  logic [63:0]      lo_r [LANES];
  logic             hinz_r [LANES];
  logic             rem_r [LANES];
  q_t               p_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DEPTH-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_in;
    for (int s = 1; s < DEPTH; s++) begin
      side_r[s] <= side_r[s-1];
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sh[i] = prod_r[i] >> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      a_r[i]    <= a[i];
      b_r[i]    <= b[i];
      neg1_r[i] <= a_r[i][63] ^ b_r[i][63];
      ma_r[i]   <= qmag(a_r[i]);
      mb_r[i]   <= qmag(b_r[i]);
      neg2_r[i] <= neg1_r[i];
      ll_r[i]   <= ma_r[i][31:0] * mb_r[i][31:0];
      lh_r[i]   <= ma_r[i][31:0] * mb_r[i][63:32];
      hl_r[i]   <= ma_r[i][63:32] * mb_r[i][31:0];
      hh_r[i]   <= ma_r[i][63:32] * mb_r[i][63:32];
      neg3_r[i] <= neg2_r[i];
      prod_r[i] <= {64'b0, ll_r[i]} + {32'b0, lh_r[i], 32'b0} + {32'b0, hl_r[i], 32'b0}
                   + {hh_r[i], 64'b0};
      neg4_r[i] <= neg3_r[i];
      lo_r[i]   <= sh[i][63:0];
      hinz_r[i] <= |sh[i][127:64];
      rem_r[i]  <= |prod_r[i][FRAC_BITS-1:0];
      p_r[i]    <= sat_mag(neg4_r[i], hinz_r[i], lo_r[i], rem_r[i]);
    end
  end

  assign out_vld  = vld_r[DEPTH-1];
  assign side_out = side_r[DEPTH-1];
  assign p        = p_r;

endmodule

### rtl/envc_qdiv.sv
module envc_qdiv import envc_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int SW        = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  q_t            num,
  input  q_t            den,
  input  logic [SW-1:0] side_in,
  output logic          out_vld,
  output q_t            quo,
  output logic [SW-1:0] side_out
);

  localparam int NQ = 64 + FRAC_BITS;

  logic          vld_r  [NQ+1];
  logic [63:0]   rem_r  [NQ+1];
  logic [NQ-1:0] num_r  [NQ+1];
  logic [63:0]   mb_r   [NQ+1];
  logic          neg_r  [NQ+1];
  logic [SW-1:0] side_r [NQ+1];
  logic          out_vld_r;
  q_t            quo_r;
  logic [SW-1:0] side_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= '0;
    num_r[0]  <= {qmag(num), {FRAC_BITS{1'b0}}};
    mb_r[0]   <= (den == '0) ? 64'd1 : qmag(den);
    neg_r[0]  <= num[63] ^ den[63];
    side_r[0] <= side_in;
  end

  for (genvar k = 0; k < NQ; k++) begin : g_step
    logic [64:0] trial;
    logic        ge;

    always_comb begin
      trial = {rem_r[k], num_r[k][NQ-1]};
      ge    = trial >= {1'b0, mb_r[k]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k+1]  <= ge ? 64'(trial - {1'b0, mb_r[k]}) : trial[63:0];
      num_r[k+1]  <= {num_r[k][NQ-2:0], ge};
      mb_r[k+1]   <= mb_r[k];
      neg_r[k+1]  <= neg_r[k];
      side_r[k+1] <= side_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[NQ];
    end
  end

  always_ff @(posedge clk) begin
    quo_r      <= sat_mag(neg_r[NQ], |num_r[NQ][NQ-1:64], num_r[NQ][63:0], |rem_r[NQ]);
    side_out_r <= side_r[NQ];
  end

  assign out_vld  = out_vld_r;
  assign quo      = quo_r;
  assign side_out = side_out_r;

endmodule

### rtl/env_sensor_compensation.sv
// Temperature, pressure and humidity compensation for one raw reading set.
// Input: a set (in_temp_adc, in_press_adc, in_humid_adc) transfers on a rising
// edge with start high and busy low. Busy stays low, so a new set may be
// offered on every clock cycle.
// Output: out_valid is high for one cycle with the result of one set on the
// out_ ports. Results leave in the order their sets arrived. The receiver
// cannot stall the block; it must take each result in the cycle it appears.
// Throughput is one set per cycle. The pipeline holds a chain of ten pipelined
// fixed-point multiplier groups of six stages each and the pressure divider,
// which resolves one quotient bit per stage over 64 + FRAC_BITS stages.
// Configuration: cfg_index selects a calibration register and cfg_data is
// written when cfg_valid is high; cfg_ready is always high. Calibration must
// only change while no set is in flight.
// Reset clears all calibration registers to zero and drops every set in
// flight; no result is produced for a set that was inside at reset.
module env_sensor_compensation import envc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [19:0]          in_temp_adc,
  input  logic [19:0]          in_press_adc,
  input  logic [15:0]          in_humid_adc,
  output logic                 out_valid,
  output logic signed [15:0]   out_temp_centi,
  output logic [24:0]          out_press_q8,
  output logic [16:0]          out_humid_q10,
  output logic                 out_press_invalid,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  typedef struct packed {
    logic [19:0]        adc_p;
    logic [15:0]        adc_h;
    q_t                 m1;
    logic signed [15:0] tc;
    logic               vh_nz;
    q_t                 x;
    q_t                 t;
    q_t                 p2a;
    q_t                 v2;
    q_t                 bs;
    q_t                 u1;
    q_t                 b;
    q_t                 pd;
    q_t                 h0;
    logic [16:0]        hum;
    logic               inval;
    q_t                 p;
    q_t                 c2;
  } ctx_t;

  localparam int SW    = $bits(ctx_t);
  localparam int LAT   = 130 + FRAC_BITS;
  localparam int SH_T  = FRAC_BITS + 8;
  localparam int SH_P  = (FRAC_BITS > 8) ? FRAC_BITS - 8 : 0;
  localparam int SH_H  = (FRAC_BITS > 10) ? FRAC_BITS - 10 : 0;
  localparam int UP_H  = (FRAC_BITS < 10) ? 10 - FRAC_BITS : 0;

  localparam q_t Q_ONE    = q_t'(1) <<< FRAC_BITS;
  localparam q_t Q_5      = q_t'(5) <<< FRAC_BITS;
  localparam q_t Q_100    = q_t'(100) <<< FRAC_BITS;
  localparam q_t Q_3125   = q_t'(3125) <<< FRAC_BITS;
  localparam q_t Q_32768  = q_t'(32768) <<< FRAC_BITS;
  localparam q_t Q_64000  = q_t'(64000) <<< FRAC_BITS;
  localparam q_t Q_76800  = q_t'(76800) <<< FRAC_BITS;
  localparam q_t RND_T    = q_t'(1) <<< (FRAC_BITS + 7);
  localparam q_t RND_P    = q_t'(SH_P > 0) <<< ((SH_P > 0) ? SH_P - 1 : 0);
  localparam q_t RND_H    = q_t'(SH_H > 0) <<< ((SH_H > 0) ? SH_H - 1 : 0);
  localparam q_t TC_MAX   = q_t'(32767);
  localparam q_t TC_MIN   = -q_t'(32768);
  localparam q_t PR_MAX   = q_t'(33554431);
  localparam q_t HUM_MAX  = q_t'(102400);
  localparam q_t P_BASE   = q_t'(1048576);

  logic [47:0] temp_cal_r;
  logic [63:0] press_a_r;
  logic [63:0] press_b_r;
  logic [15:0] press_c_r;
  logic [63:0] humid_cal_r;

  q_t t2q, t3q, p1q, p2q, p3q, p4q, p5q, p6q, p7q, p8q, p9q;
  q_t h1q, h2q, h3q, h5q, h6q;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r  <= '0;
      press_a_r   <= '0;
      press_b_r   <= '0;
      press_c_r   <= '0;
      humid_cal_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TEMP_CAL:  temp_cal_r  <= cfg_data[47:0];
        CFG_PRESS_A:   press_a_r   <= cfg_data;
        CFG_PRESS_B:   press_b_r   <= cfg_data;
        CFG_PRESS_C:   press_c_r   <= cfg_data[15:0];
        CFG_HUMID_CAL: humid_cal_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    t2q = q_t'($signed(temp_cal_r[31:16])) <<< FRAC_BITS;
    t3q = q_t'($signed(temp_cal_r[47:32])) <<< FRAC_BITS;
    p1q = q_t'({1'b0, press_a_r[15:0]}) <<< FRAC_BITS;
    p2q = q_t'($signed(press_a_r[31:16])) <<< FRAC_BITS;
    p3q = q_t'($signed(press_a_r[47:32])) <<< FRAC_BITS;
    p4q = q_t'($signed(press_a_r[63:48])) <<< (FRAC_BITS + 16);
    p5q = q_t'($signed(press_b_r[15:0])) <<< FRAC_BITS;
    p6q = q_t'($signed(press_b_r[31:16])) <<< FRAC_BITS;
    p7q = q_t'($signed(press_b_r[47:32])) <<< FRAC_BITS;
    p8q = q_t'($signed(press_b_r[63:48])) <<< FRAC_BITS;
    p9q = q_t'($signed(press_c_r)) <<< FRAC_BITS;
    h1q = q_t'({1'b0, humid_cal_r[7:0]}) <<< FRAC_BITS;
    h2q = q_t'($signed(humid_cal_r[23:8])) <<< FRAC_BITS;
    h3q = q_t'({1'b0, humid_cal_r[31:24]}) <<< FRAC_BITS;
    h5q = q_t'($signed(humid_cal_r[55:44])) <<< FRAC_BITS;
    h6q = q_t'($signed(humid_cal_r[63:56])) <<< FRAC_BITS;
  end

  // Input register.
  logic        in_vld_r;
  logic [19:0] adc_t_r;
  ctx_t        ctx_in_nxt, ctx_in_r;

  always_comb begin
    ctx_in_nxt       = '0;
    ctx_in_nxt.adc_p = in_press_adc;
    ctx_in_nxt.adc_h = in_humid_adc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    adc_t_r  <= in_temp_adc;
    ctx_in_r <= ctx_in_nxt;
  end

  // Group 1: temperature linear and square terms.
  q_t   xt;
  q_t   g1_a [2], g1_b [2], g1_o [2];
  logic g1_ov;
  ctx_t g1_so;

  always_comb begin
    xt      = (q_t'({1'b0, adc_t_r}) - q_t'({1'b0, temp_cal_r[15:0], 4'b0})) <<< FRAC_BITS;
    g1_a[0] = xt >>> 14;
    g1_b[0] = t2q;
    g1_a[1] = xt >>> 17;
    g1_b[1] = xt >>> 17;
  end

  envc_qmul #(.FRAC_BITS(FRAC_BITS), .LANES(2), .SW(SW)) u_g1 (
    .clk(clk), .rst_n(rst_n), .in_vld(in_vld_r), .a(g1_a), .b(g1_b), .side_in(ctx_in_r),
    .out_vld(g1_ov), .p(g1_o), .side_out(g1_so)
  );

  // Group 2: square term times T3.
  q_t   g2_a [1], g2_b [1], g2_o [1];
  ctx_t g2_si, g2_so;
  logic g2_ov;

  always_comb begin
    g2_si    = g1_so;
    g2_si.m1 = g1_o[0];
    g2_a[0]  = g1_o[1];
    g2_b[0]  = t3q;
  end

  envc_qmul #(.FRAC_BITS(FRAC_BITS), .LANES(1), .SW(SW)) u_g2 (
    .clk(clk), .rst_n(rst_n), .in_vld(g1_ov), .a(g2_a), .b(g2_b), .side_in(g2_si),
    .out_vld(g2_ov), .p(g2_o), .side_out(g2_so)
  );

  // Group 3: products of the fine temperature and its offsets.
  q_t   tf, pa, vh;
  q_t   g3_a [7], g3_b [7], g3_o [7];
  ctx_t g3_si, g3_so;
  logic g3_ov;

  always_comb begin
    tf          = sadd(g2_so.m1, g2_o[0]);
    pa          = ssub(tf >>> 1, Q_64000);
    vh          = ssub(tf, Q_76800);
    g3_si       = g2_so;
    g3_si.vh_nz = vh != '0;
    g3_a[0] = tf;        g3_b[0] = Q_5;
    g3_a[1] = pa >>> 2;  g3_b[1] = pa >>> 2;
    g3_a[2] = pa;        g3_b[2] = p5q;
    g3_a[3] = p2q;       g3_b[3] = pa;
    g3_a[4] = h5q;       g3_b[4] = vh;
    g3_a[5] = h3q;       g3_b[5] = vh;
    g3_a[6] = h6q;       g3_b[6] = vh;
  end

  envc_qmul #(.FRAC_BITS(FRAC_BITS), .LANES(7), .SW(SW)) u_g3 (
    .clk(clk), .rst_n(rst_n), .in_vld(g2_ov), .a(g3_a), .b(g3_b), .side_in(g3_si),
    .out_vld(g3_ov), .p(g3_o), .side_out(g3_so)
  );

  // Group 4: second-order pressure terms and the humidity temperature factor.
  q_t   tcw, hadc, th;
  q_t   g4_a [3], g4_b [3], g4_o [3];
  ctx_t g4_si, g4_so;
  logic g4_ov;

  always_comb begin
    tcw   = sadd(g3_o[0], RND_T) >>> SH_T;
    hadc  = (q_t'({1'b0, g3_so.adc_h}) - (q_t'($signed(humid_cal_r[43:32])) <<< 6))
            <<< FRAC_BITS;
    th    = sadd(Q_ONE, g3_o[5] >>> 26);
    g4_si = g3_so;
    if (tcw > TC_MAX) begin
      g4_si.tc = 16'sh7fff;
    end else if (tcw < TC_MIN) begin
      g4_si.tc = 16'sh8000;
    end else begin
      g4_si.tc = 16'(tcw);
    end
    g4_si.x   = ssub(hadc, g3_o[4] >>> 14);
    g4_si.t   = g3_o[2];
    g4_si.p2a = g3_o[3];
    g4_a[0] = g3_o[1] >>> 11;  g4_b[0] = p6q;
    g4_a[1] = p3q;             g4_b[1] = g3_o[1] >>> 13;
    g4_a[2] = g3_o[6] >>> 26;  g4_b[2] = th;
  end

  envc_qmul #(.FRAC_BITS(FRAC_BITS), .LANES(3), .SW(SW)) u_g4 (
    .clk(clk), .rst_n(rst_n), .in_vld(g3_ov), .a(g4_a), .b(g4_b), .side_in(g4_si),
    .out_vld(g4_ov), .p(g4_o), .side_out(g4_so)
  );

  // Sum stage after group 4.
  logic r4_vld_r;
  ctx_t r4_nxt, r4_r;

  always_comb begin
    r4_nxt    = g4_so;
    r4_nxt.v2 = sadd(g4_o[0], sadd(g4_so.t, g4_so.t));
    r4_nxt.bs = sadd(g4_o[1] >>> 3, g4_so.p2a >>> 1);
    r4_nxt.u1 = sadd(Q_ONE, g4_o[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r4_vld_r <= 1'b0;
    end else begin
      r4_vld_r <= g4_ov;
    end
  end

  always_ff @(posedge clk) begin
    r4_r <= r4_nxt;
  end

  // Group 5: pressure scale and humidity gain.
  q_t   g5_a [2], g5_b [2], g5_o [2];
  ctx_t g5_si, g5_so;
  logic g5_ov;

  always_comb begin
    g5_si    = r4_r;
    g5_si.v2 = sadd(r4_r.v2 >>> 2, p4q);
    g5_a[0]  = sadd(Q_32768, r4_r.bs >>> 18);
    g5_b[0]  = p1q;
    g5_a[1]  = h2q;
    g5_b[1]  = r4_r.u1;
  end

  envc_qmul #(.FRAC_BITS(FRAC_BITS), .LANES(2), .SW(SW)) u_g5 (
    .clk(clk), .rst_n(rst_n), .in_vld(r4_vld_r), .a(g5_a), .b(g5_b), .side_in(g5_si),
    .out_vld(g5_ov), .p(g5_o), .side_out(g5_so)
  );

  // Group 6: raw pressure numerator and humidity product.
  q_t   pq;
  q_t   g6_a [2], g6_b [2], g6_o [2];
  ctx_t g6_si, g6_so;
  logic g6_ov;

  always_comb begin
    pq      = ssub((P_BASE - q_t'({1'b0, g5_so.adc_p})) <<< FRAC_BITS, g5_so.v2 >>> 12);
    g6_si   = g5_so;
    g6_si.b = g5_o[0] >>> 15;
    g6_a[0] = pq;
    g6_b[0] = Q_3125;
    g6_a[1] = g5_so.x;
    g6_b[1] = g5_o[1] >>> 16;
  end

  envc_qmul #(.FRAC_BITS(FRAC_BITS), .LANES(2), .SW(SW)) u_g6 (
    .clk(clk), .rst_n(rst_n), .in_vld(g5_ov), .a(g6_a), .b(g6_b), .side_in(g6_si),
    .out_vld(g6_ov), .p(g6_o), .side_out(g6_so)
  );

  // Group 7: humidity self term.
  q_t   g7_a [1], g7_b [1], g7_o [1];
  ctx_t g7_si, g7_so;
  logic g7_ov;

  always_comb begin
    g7_si    = g6_so;
    g7_si.pd = sadd(g6_o[0], g6_o[0]);
    g7_si.h0 = g6_o[1];
    g7_a[0]  = h1q;
    g7_b[0]  = g6_o[1];
  end

  envc_qmul #(.FRAC_BITS(FRAC_BITS), .LANES(1), .SW(SW)) u_g7 (
    .clk(clk), .rst_n(rst_n), .in_vld(g6_ov), .a(g7_a), .b(g7_b), .side_in(g7_si),
    .out_vld(g7_ov), .p(g7_o), .side_out(g7_so)
  );

  // Group 8: final humidity product.
  q_t   g8_a [1], g8_b [1], g8_o [1];
  ctx_t g8_so;
  logic g8_ov;

  always_comb begin
    g8_a[0] = g7_so.h0;
    g8_b[0] = ssub(Q_ONE, g7_o[0] >>> 19);
  end

  envc_qmul #(.FRAC_BITS(FRAC_BITS), .LANES(1), .SW(SW)) u_g8 (
    .clk(clk), .rst_n(rst_n), .in_vld(g7_ov), .a(g8_a), .b(g8_b), .side_in(g7_so),
    .out_vld(g8_ov), .p(g8_o), .side_out(g8_so)
  );

  // Humidity result and pressure division.
  q_t   hcl, hrs;
  ctx_t dv_si, dv_so;
  q_t   dv_q;
  logic dv_ov;

  always_comb begin
    if (g8_o[0] > Q_100) begin
      hcl = Q_100;
    end else if (g8_o[0] < 0) begin
      hcl = '0;
    end else begin
      hcl = g8_o[0];
    end
    hrs         = ((hcl + RND_H) >>> SH_H) <<< UP_H;
    dv_si       = g8_so;
    dv_si.inval = g8_so.b == '0;
    if (!g8_so.vh_nz) begin
      dv_si.hum = '0;
    end else if (hrs > HUM_MAX) begin
      dv_si.hum = 17'(HUM_MAX);
    end else begin
      dv_si.hum = 17'(hrs);
    end
  end

  envc_qdiv #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_div (
    .clk(clk), .rst_n(rst_n), .in_vld(g8_ov), .num(g8_so.pd), .den(g8_so.b),
    .side_in(dv_si), .out_vld(dv_ov), .quo(dv_q), .side_out(dv_so)
  );

  // Group 9: pressure square and P8 terms.
  q_t   g9_a [2], g9_b [2], g9_o [2];
  ctx_t g9_si, g9_so;
  logic g9_ov;

  always_comb begin
    g9_si   = dv_so;
    g9_si.p = dv_q;
    g9_a[0] = dv_q >>> 3;
    g9_b[0] = dv_q >>> 3;
    g9_a[1] = dv_q >>> 2;
    g9_b[1] = p8q;
  end

  envc_qmul #(.FRAC_BITS(FRAC_BITS), .LANES(2), .SW(SW)) u_g9 (
    .clk(clk), .rst_n(rst_n), .in_vld(dv_ov), .a(g9_a), .b(g9_b), .side_in(g9_si),
    .out_vld(g9_ov), .p(g9_o), .side_out(g9_so)
  );

  // Group 10: P9 term.
  q_t   g10_a [1], g10_b [1], g10_o [1];
  ctx_t g10_si, g10_so;
  logic g10_ov;

  always_comb begin
    g10_si    = g9_so;
    g10_si.c2 = g9_o[1] >>> 13;
    g10_a[0]  = p9q;
    g10_b[0]  = g9_o[0] >>> 13;
  end

  envc_qmul #(.FRAC_BITS(FRAC_BITS), .LANES(1), .SW(SW)) u_g10 (
    .clk(clk), .rst_n(rst_n), .in_vld(g9_ov), .a(g10_a), .b(g10_b), .side_in(g10_si),
    .out_vld(g10_ov), .p(g10_o), .side_out(g10_so)
  );

  // Correction sum, then output register.
  logic r10_vld_r;
  ctx_t r10_nxt, r10_r;

  always_comb begin
    r10_nxt    = g10_so;
    r10_nxt.c2 = sadd(sadd(g10_o[0] >>> 12, g10_so.c2), p7q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r10_vld_r <= 1'b0;
    end else begin
      r10_vld_r <= g10_ov;
    end
  end

  always_ff @(posedge clk) begin
    r10_r <= r10_nxt;
  end

  q_t                 pf, pr;
  logic [24:0]        press_nxt;
  logic               out_valid_r;
  logic signed [15:0] out_temp_centi_r;
  logic [24:0]        out_press_q8_r;
  logic [16:0]        out_humid_q10_r;
  logic               out_press_invalid_r;

  always_comb begin
    pf = sadd(r10_r.p, r10_r.c2 >>> 4);
    pr = sadd(pf, RND_P) >>> SH_P;
    if (r10_r.inval || pr < 0) begin
      press_nxt = '0;
    end else if (pr > PR_MAX) begin
      press_nxt = 25'(PR_MAX);
    end else begin
      press_nxt = 25'(pr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= r10_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_temp_centi_r    <= r10_r.tc;
    out_press_q8_r      <= press_nxt;
    out_humid_q10_r     <= r10_r.hum;
    out_press_invalid_r <= r10_r.inval;
  end

  assign out_valid         = out_valid_r;
  assign out_temp_centi    = out_temp_centi_r;
  assign out_press_q8      = out_press_q8_r;
  assign out_humid_q10     = out_humid_q10_r;
  assign out_press_invalid = out_press_invalid_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_press_invalid |-> out_press_q8 == '0)
    else $error("Pressure flagged invalid but not forced to zero.");

  a_humid_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_humid_q10 <= 17'd102400)
    else $error("Humidity result above full scale.");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_valid)
    else $error("Result did not appear at the expected latency after a transfer.");

endmodule
